FILE: rtl/core/atcw_pkg.sv
// shared types, constants and the colour palette for the ansi text console writer
`timescale 1ns / 1ps
`default_nettype none

package atcw_pkg;

	localparam int COLS_W  = 10;
	localparam int SLOT_OW = 10;
	localparam int COL_OW  = 9;
	localparam int RGB_W   = 24;

	localparam logic [RGB_W-1:0] FORE_DEFAULT = 24'hC0C0C0;
	localparam logic [RGB_W-1:0] BACK_DEFAULT = 24'h000000;
	localparam logic [COLS_W-1:0] COLS_RESET  = 10'd80;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic KIND_CELL  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [SLOT_OW-1:0] line_slot;
		logic [COL_OW-1:0]  column;
		logic [7:0]         glyph;
		logic [RGB_W-1:0]   fore;
		logic [RGB_W-1:0]   back;
		logic               last;
	} atcw_result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic sgr_step;
		logic sel;
	} atcw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] n_res;
		logic       sgr_go;
		logic       sgr_last;
	} atcw_status_t;

	function automatic logic [RGB_W-1:0] palette16(input logic [3:0] idx);
		logic [RGB_W-1:0] rgb;
		case (idx)
			4'd0:    rgb = 24'h000000;
			4'd1:    rgb = 24'hAA0000;
			4'd2:    rgb = 24'h00AA00;
			4'd3:    rgb = 24'hAA5500;
			4'd4:    rgb = 24'h0000AA;
			4'd5:    rgb = 24'hAA00AA;
			4'd6:    rgb = 24'h00AAAA;
			4'd7:    rgb = 24'hAAAAAA;
			4'd8:    rgb = 24'h555555;
			4'd9:    rgb = 24'hFF5555;
			4'd10:   rgb = 24'h55FF55;
			4'd11:   rgb = 24'hFFFF55;
			4'd12:   rgb = 24'h5555FF;
			4'd13:   rgb = 24'hFF55FF;
			4'd14:   rgb = 24'h55FFFF;
			default: rgb = 24'hFFFFFF;
		endcase
		return rgb;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/atcw_ifs.sv
// request channel interfaces: console bytes in, cell and line writes out
`timescale 1ns / 1ps
`default_nettype none

interface atcw_in_if import atcw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] byte_in;

	modport source(output valid, op, byte_in, input ready);
	modport sink(input valid, op, byte_in, output ready);
endinterface

interface atcw_out_if import atcw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [SLOT_OW-1:0] line_slot;
	logic [COL_OW-1:0]  column;
	logic [7:0]         glyph;
	logic [RGB_W-1:0]   fore;
	logic [RGB_W-1:0]   back;
	logic               last;

	modport source(output valid, kind, line_slot, column, glyph, fore, back, last, input ready);
	modport sink(input valid, kind, line_slot, column, glyph, fore, back, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/atcw_ctrl.sv
// controller: sequences accept, sgr walk and delivery of up to two results
`timescale 1ns / 1ps
`default_nettype none

module atcw_ctrl import atcw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  atcw_status_t status,
	output atcw_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SGR  = 2'd1;
	localparam logic [1:0] ST_OUT0 = 2'd2;
	localparam logic [1:0] ST_OUT1 = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       two_q;
	logic       in_fire;
	logic       out_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	assign cmd.accept   = in_fire;
	assign cmd.sgr_step = (state_q == ST_SGR);
	assign cmd.sel      = (state_q == ST_OUT1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (status.n_res != 2'd0) begin
						state_d = ST_OUT0;
					end else if (status.sgr_go) begin
						state_d = ST_SGR;
					end
				end
			end
			ST_SGR: begin
				if (status.sgr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT0: begin
				if (out_fire) begin
					state_d = two_q ? ST_OUT1 : ST_IDLE;
				end
			end
			ST_OUT1: begin
				if (out_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			two_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				two_q <= (status.n_res == 2'd2);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/atcw_dp.sv
// datapath: escape parser, sgr colour state, cursor, ring slots and result registers
`timescale 1ns / 1ps
`default_nettype none

module atcw_dp import atcw_pkg::*; #(
	parameter int RING_LINES  = 1024,
	parameter int MAX_PARAMS  = 8,
	parameter int MAX_COLUMNS = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [COLS_W-1:0] cfg_wdata,
	input  logic              op,
	input  logic [7:0]        byte_in,
	input  atcw_cmd_t         cmd,
	output atcw_status_t      status,
	output atcw_result_t      result
);

	localparam int SLOT_W = $clog2(RING_LINES);
	localparam int LT_W   = $clog2(RING_LINES + 1);
	localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
	localparam int PIDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESC    = 2'd1;
	localparam logic [1:0] MODE_CSI    = 2'd2;

	logic [COLS_W-1:0] columns_q;
	logic [1:0]        mode_q, mode_d;
	logic [PIDX_W-1:0] count_q, count_d;
	logic [31:0]       acc_q, acc_d;
	logic [31:0]       params_q [MAX_PARAMS];
	logic              pwr_en;
	logic [RGB_W-1:0]  fore_q, back_q, sgr_fore, sgr_back;
	logic [COL_W-1:0]  cursor_q, cursor_d, eff_cols;
	logic [LT_W-1:0]   lt_q, lt_d;
	logic [SLOT_W-1:0] head_q, head_d, cur_slot, new_slot;
	logic [SLOT_W:0]   slot_sum, head_sum, next_sum;
	logic [PIDX_W-1:0] sgr_idx_q, sgr_last_q;
	logic              sgr_go;
	logic [1:0]        n_res;
	logic [31:0]       p;
	atcw_result_t      res0_q, res1_q, res0_d, res1_d;

	function automatic atcw_result_t mk_res(input logic kind, input logic [SLOT_W-1:0] slot,
			input logic [COL_W-1:0] col, input logic [7:0] glyph,
			input logic [RGB_W-1:0] fg, input logic [RGB_W-1:0] bg, input logic last);
		atcw_result_t r;
		r.kind      = kind;
		r.line_slot = SLOT_OW'(slot);
		r.column    = COL_OW'(col);
		r.glyph     = glyph;
		r.fore      = fg;
		r.back      = bg;
		r.last      = last;
		return r;
	endfunction

	// slot of the newest line and the one after it, both modulo the ring size
	always_comb begin
		slot_sum = (SLOT_W+1)'(head_q) + (SLOT_W+1)'(lt_q - LT_W'(1));
		if (slot_sum >= (SLOT_W+1)'(RING_LINES)) begin
			cur_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(RING_LINES));
		end else begin
			cur_slot = SLOT_W'(slot_sum);
		end
		next_sum = (SLOT_W+1)'(cur_slot) + (SLOT_W+1)'(1);
		new_slot = (next_sum == (SLOT_W+1)'(RING_LINES)) ? '0 : SLOT_W'(next_sum);
		head_sum = (SLOT_W+1)'(head_q) + (SLOT_W+1)'(1);
	end

	always_comb begin
		if (columns_q == '0) begin
			eff_cols = COL_W'(1);
		end else if (32'(columns_q) > MAX_COLUMNS) begin
			eff_cols = COL_W'(MAX_COLUMNS);
		end else begin
			eff_cols = COL_W'(columns_q);
		end
	end

	// one sgr parameter per cycle
	always_comb begin
		p        = params_q[sgr_idx_q];
		sgr_fore = fore_q;
		sgr_back = back_q;
		if (p == 32'd0) begin
			sgr_fore = FORE_DEFAULT;
			sgr_back = BACK_DEFAULT;
		end else if (p == 32'd39) begin
			sgr_fore = FORE_DEFAULT;
		end else if (p == 32'd49) begin
			sgr_back = BACK_DEFAULT;
		end else if (p inside {[32'd30:32'd37]}) begin
			sgr_fore = palette16(4'(p - 32'd30));
		end else if (p inside {[32'd90:32'd97]}) begin
			sgr_fore = palette16(4'(p - 32'd82));
		end else if (p inside {[32'd40:32'd47]}) begin
			sgr_back = palette16(4'(p - 32'd40));
		end else if (p inside {[32'd100:32'd107]}) begin
			sgr_back = palette16(4'(p - 32'd92));
		end
	end

	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		acc_d    = acc_q;
		pwr_en   = 1'b0;
		cursor_d = cursor_q;
		lt_d     = lt_q;
		head_d   = head_q;
		sgr_go   = 1'b0;
		n_res    = 2'd0;
		res0_d   = mk_res(KIND_CLEAR, new_slot, '0, CH_SPACE, fore_q, back_q, 1'b1);
		res1_d   = mk_res(KIND_CELL, new_slot, '0, byte_in, fore_q, back_q, 1'b1);
		if (op == OP_CLEAR) begin
			mode_d   = MODE_NORMAL;
			count_d  = '0;
			acc_d    = '0;
			head_d   = '0;
			lt_d     = LT_W'(1);
			cursor_d = '0;
			n_res    = 2'd1;
			res0_d   = mk_res(KIND_CLEAR, '0, '0, CH_SPACE, fore_q, back_q, 1'b1);
		end else begin
			case (mode_q)
				MODE_ESC: begin
					mode_d  = (byte_in == CH_LBRK) ? MODE_CSI : MODE_NORMAL;
					count_d = '0;
					acc_d   = '0;
				end
				MODE_CSI: begin
					if (byte_in inside {[CH_ZERO:CH_NINE]}) begin
						acc_d = (acc_q << 3) + (acc_q << 1) + 32'(byte_in - CH_ZERO);
					end else if (byte_in == CH_SEMI) begin
						if ((PIDX_W+1)'(count_q) + (PIDX_W+1)'(1) < (PIDX_W+1)'(MAX_PARAMS)) begin
							pwr_en  = 1'b1;
							count_d = count_q + PIDX_W'(1);
							acc_d   = '0;
						end
					end else begin
						pwr_en  = 1'b1;
						sgr_go  = (byte_in == CH_M);
						mode_d  = MODE_NORMAL;
						count_d = '0;
						acc_d   = '0;
					end
				end
				default: begin
					if (byte_in == CH_ESC) begin
						mode_d = MODE_ESC;
					end else if (byte_in == CH_LF) begin
						n_res    = 2'd1;
						cursor_d = '0;
						if (lt_q < LT_W'(RING_LINES)) begin
							lt_d = lt_q + LT_W'(1);
						end else begin
							head_d = (head_sum == (SLOT_W+1)'(RING_LINES)) ? '0 : SLOT_W'(head_sum);
						end
					end else if (byte_in == CH_BS) begin
						if (cursor_q != '0) begin
							n_res    = 2'd1;
							cursor_d = cursor_q - COL_W'(1);
							res0_d   = mk_res(KIND_CELL, cur_slot, cursor_q - COL_W'(1), CH_SPACE,
								fore_q, back_q, 1'b1);
						end
					end else if (cursor_q >= eff_cols) begin
						// wrap: clear the new line, then the cell at its column zero
						n_res    = 2'd2;
						cursor_d = COL_W'(1);
						res0_d.last = 1'b0;
						if (lt_q < LT_W'(RING_LINES)) begin
							lt_d = lt_q + LT_W'(1);
						end else begin
							head_d = (head_sum == (SLOT_W+1)'(RING_LINES)) ? '0 : SLOT_W'(head_sum);
						end
					end else begin
						n_res    = 2'd1;
						cursor_d = cursor_q + COL_W'(1);
						res0_d   = mk_res(KIND_CELL, cur_slot, cursor_q, byte_in, fore_q, back_q, 1'b1);
					end
				end
			endcase
		end
	end

	assign status.n_res    = n_res;
	assign status.sgr_go   = sgr_go;
	assign status.sgr_last = (sgr_idx_q == sgr_last_q);
	assign result          = cmd.sel ? res1_q : res0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q  <= COLS_RESET;
			mode_q     <= MODE_NORMAL;
			count_q    <= '0;
			acc_q      <= '0;
			fore_q     <= FORE_DEFAULT;
			back_q     <= BACK_DEFAULT;
			cursor_q   <= '0;
			lt_q       <= LT_W'(1);
			head_q     <= '0;
			sgr_idx_q  <= '0;
			sgr_last_q <= '0;
		end else begin
			if (cfg_we) begin
				columns_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				mode_q   <= mode_d;
				count_q  <= count_d;
				acc_q    <= acc_d;
				cursor_q <= cursor_d;
				lt_q     <= lt_d;
				head_q   <= head_d;
				if (sgr_go) begin
					sgr_idx_q  <= '0;
					sgr_last_q <= count_q;
				end
			end
			if (cmd.sgr_step) begin
				fore_q    <= sgr_fore;
				back_q    <= sgr_back;
				sgr_idx_q <= sgr_idx_q + PIDX_W'(1);
			end
		end
	end

	// parameter slots are always written before the walk reads them
	always_ff @(posedge clk) begin
		if (cmd.accept && pwr_en) begin
			params_q[count_q] <= acc_q;
		end
		if (cmd.accept) begin
			res0_q <= res0_d;
			res1_q <= res1_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ansi_text_console_writer_core.sv
// top level of the ansi text console writer: controller, datapath and checks
//
// usage
//   console: request channel of console bytes (op 0) or a scrollback clear (op 1)
//   writes : request channel of cell writes (kind 0) and line-slot clears (kind 1),
//            each carrying the slot, column, glyph and the colours in force
//   cfg_we / cfg_wdata: writes the column count; only while the block is idle
// timing
//   a request is taken only when nothing is in flight; its first result shows in
//   the cycle after acceptance and stays until taken; a wrapping printable byte
//   gives two results and a parser byte none
//   the final 'm' of an sgr sequence walks the stored parameters one per cycle
//   through a single read of the parameter file
//   'last' marks the final result of each request
// reset
//   parser normal, colours c0c0c0 on black, cursor 0, one line at slot 0,
//   80 columns; no clearing pass is needed
// stalls
//   while the receiver holds ready low the result register holds and console
//   ready stays low
`timescale 1ns / 1ps
`default_nettype none

module ansi_text_console_writer_core import atcw_pkg::*; #(
	parameter int RING_LINES  = 1024,
	parameter int MAX_PARAMS  = 8,
	parameter int MAX_COLUMNS = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [COLS_W-1:0] cfg_wdata,
	atcw_in_if.sink           console,
	atcw_out_if.source        writes
);

	atcw_cmd_t    cmd;
	atcw_status_t status;
	atcw_result_t result;

	// state machine: idle / sgr walk / first result / second result
	atcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (console.valid),
		.in_ready  (console.ready),
		.out_valid (writes.valid),
		.out_ready (writes.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// parser, colour and cursor state plus the two result registers
	atcw_dp #(
		.RING_LINES  (RING_LINES),
		.MAX_PARAMS  (MAX_PARAMS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (console.op),
		.byte_in   (console.byte_in),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// result fields straight from the selected result register
	assign writes.kind      = result.kind;
	assign writes.line_slot = result.line_slot;
	assign writes.column    = result.column;
	assign writes.glyph     = result.glyph;
	assign writes.fore      = result.fore;
	assign writes.back      = result.back;
	assign writes.last      = result.last;

`ifndef ASSERT_OFF
	// never take a new request while a result is still on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(console.ready && writes.valid))
		else $error("console request taken while a result is pending");

	// a scrollback clear is answered next cycle by a final clear of slot zero
	a_clear_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(console.valid && console.ready && console.op == OP_CLEAR) |=>
		(writes.valid && writes.kind == KIND_CLEAR && writes.line_slot == '0 && writes.last))
		else $error("clear request not answered by slot zero clear");

	// line clears always carry column zero and a blank
	a_clear_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(writes.valid && writes.kind == KIND_CLEAR) |->
		(writes.column == '0 && writes.glyph == CH_SPACE))
		else $error("line clear with non-zero column or non-blank glyph");

	// after the final result of a request nothing more is offered
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(writes.valid && writes.ready && writes.last) |=> !writes.valid)
		else $error("result offered after the final one");

	// a non-final result is followed by a cell write to the same slot
	a_wrap_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(writes.valid && writes.ready && !writes.last) |=>
		(writes.valid && writes.kind == KIND_CELL && writes.column == '0 &&
		writes.line_slot == $past(writes.line_slot)))
		else $error("wrap clear not followed by cell write at column zero");
`endif

endmodule

`default_nettype wire
